[hw/rtl/dmpsc_pkg.sv]
// ----------------------------------------------------------------------------
// Dual motor PI speed control package
// Shared constants, register indexes, payload and register bank types, and
// the signed saturation helper used by the controller.
// ----------------------------------------------------------------------------
package dmpsc_pkg;

	localparam int MOTOR_COUNT_DEF   = 2;
	localparam int FRACTION_BITS_DEF = 16;

	localparam int REG_COUNT = 8;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_W     = 31;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P        = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I        = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GEAR_RATIO    = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE   = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BACK_EMF_GAIN = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CUR_LIMIT_V   = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_LIMIT = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_SCALE  = 4'd7;

	localparam logic [CFG_W-1:0] RST_GAIN_P        = 31'd2720;
	localparam logic [CFG_W-1:0] RST_GAIN_I        = 31'd22066;
	localparam logic [CFG_W-1:0] RST_GEAR_RATIO    = 31'd1245184;
	localparam logic [CFG_W-1:0] RST_SPEED_SCALE   = 31'd1245433;
	localparam logic [CFG_W-1:0] RST_BACK_EMF_GAIN = 31'd2479;
	localparam logic [CFG_W-1:0] RST_CUR_LIMIT_V   = 31'd313839;
	localparam logic [CFG_W-1:0] RST_VOLTAGE_LIMIT = 31'd1572864;
	localparam logic [CFG_W-1:0] RST_OUTPUT_SCALE  = 31'd273067;

	localparam logic signed [32:0] S33_MAX = 33'sd2147483647;
	localparam logic signed [32:0] S33_MIN = -33'sd2147483648;

	typedef struct packed {
		logic signed [31:0] left_speed_ref;
		logic signed [31:0] right_speed_ref;
		logic signed [31:0] left_wheel_speed;
		logic signed [31:0] right_wheel_speed;
		logic [30:0]        time_step;
	} in_item_t;

	typedef struct packed {
		logic signed [23:0] left_command;
		logic signed [23:0] right_command;
		logic               left_current_limited;
		logic               left_voltage_limited;
		logic               right_current_limited;
		logic               right_voltage_limited;
	} out_item_t;

	typedef struct packed {
		logic [CFG_W-1:0] gain_p;
		logic [CFG_W-1:0] gain_i;
		logic [CFG_W-1:0] gear_ratio;
		logic [CFG_W-1:0] speed_scale;
		logic [CFG_W-1:0] back_emf_gain;
		logic [CFG_W-1:0] current_limit_voltage;
		logic [CFG_W-1:0] voltage_limit;
		logic [CFG_W-1:0] output_scale;
	} cfg_regs_t;

	// Clip a 33-bit signed sum to the signed 32-bit range.
	function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
		logic signed [31:0] r;
		if (v > S33_MAX) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < S33_MIN) begin
			r = 32'sh8000_0000;
		end else begin
			r = $signed(v[31:0]);
		end
		return r;
	endfunction

endpackage

[hw/rtl/dual_motor_pi_speed_control.sv]
// ----------------------------------------------------------------------------
// Dual motor PI speed controller with anti-windup
// Per tick, scales each wheel speed to motor speed, runs a clamped PI term
// plus back-EMF feedforward, and returns percent-of-supply commands.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake             Payload
//   in        into       in_valid / in_stall   in_item_t  (refs, speeds, dt)
//   out       out of     out_valid / out_stall out_item_t (commands, flags)
//   cfg       into       cfg_valid / cfg_ready cfg_index, cfg_data
//
// In each transaction fourteen products (seven per motor) run one after
// another through a single radix-4 serial multiplier, each in the steps
// load, 16 digit steps, saturation and hand-back; the result then moves
// to the output register and the controller goes back to idle.
// Reset clears the integrators of both motors and restores the settings.
// A result that is stalled waits in the output register; the next input
// transaction is taken meanwhile, and a later result waits until it drains.
// ----------------------------------------------------------------------------
module dual_motor_pi_speed_control
	import dmpsc_pkg::*;
#(
	parameter int MOTOR_COUNT   = MOTOR_COUNT_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	// Integrator entry width; a single motor still gets a one-bit index.
	localparam int IDX_W       = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
	localparam int RIGHT_ENTRY = (MOTOR_COUNT > 1) ? 1 : 0;

	localparam logic signed [31:0] CMD_LIM  = 32'sd100 <<< FRACTION_BITS;
	localparam logic signed [31:0] CMD_MAX  = 32'sd8388607;
	localparam logic signed [31:0] CMD_MIN  = -32'sd8388608;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_START = 2'd1;
	localparam logic [1:0] ST_WAIT  = 2'd2;
	localparam logic [1:0] ST_OUT   = 2'd3;

	// Product sequence within one motor.
	localparam logic [2:0] OP_MS    = 3'd0;
	localparam logic [2:0] OP_DELTA = 3'd1;
	localparam logic [2:0] OP_ACC   = 3'd2;
	localparam logic [2:0] OP_PROP  = 3'd3;
	localparam logic [2:0] OP_PI    = 3'd4;
	localparam logic [2:0] OP_FF    = 3'd5;
	localparam logic [2:0] OP_CMD   = 3'd6;

	cfg_regs_t regs;

	logic [1:0]         state_q;
	logic [2:0]         op_q;
	logic               lane_q;
	in_item_t           in_q;
	out_item_t          res_q;
	out_item_t          out_q;
	logic               out_valid_q;
	logic signed [31:0] integ_q [MOTOR_COUNT];
	logic signed [31:0] ms_q;
	logic signed [31:0] delta_q;
	logic signed [31:0] acc_q;
	logic signed [31:0] p_q;
	logic signed [31:0] pi_q;
	logic signed [31:0] ua_q;
	logic               cs_q;
	logic               vs_q;

	logic               mul_start;
	logic signed [31:0] mul_a;
	logic [30:0]        mul_b;
	logic               mul_done;
	logic signed [31:0] mul_res;

	logic [IDX_W-1:0]   entry;
	logic signed [31:0] integ_rd;
	logic signed [31:0] ref_sel;
	logic signed [31:0] ws_sel;
	logic signed [31:0] delta_n;
	logic signed [31:0] acc_n;
	logic signed [31:0] pi_raw;
	logic signed [31:0] pi_n;
	logic               cs_n;
	logic signed [31:0] ua_raw;
	logic signed [31:0] ua_n;
	logic               vs_n;
	logic signed [31:0] cmd_lim;
	logic signed [31:0] cmd_clip;
	logic signed [32:0] ilim;
	logic signed [32:0] vlim;
	logic               out_free;

	dmpsc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	dmpsc_serial_mul #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.result (mul_res)
	);

	// With a single motor both lanes work on the one integrator, the right
	// lane seeing whatever the left lane has just left there.
	assign entry    = lane_q ? IDX_W'(RIGHT_ENTRY) : '0;
	assign integ_rd = integ_q[entry];
	assign ref_sel  = lane_q ? in_q.right_speed_ref  : in_q.left_speed_ref;
	assign ws_sel   = lane_q ? in_q.right_wheel_speed : in_q.left_wheel_speed;

	assign mul_start = (state_q == ST_START);

	always_comb begin
		unique case (op_q)
			OP_MS: begin
				mul_a = ws_sel;
				mul_b = regs.speed_scale;
			end
			OP_DELTA: begin
				mul_a = ref_sel;
				mul_b = regs.gear_ratio;
			end
			OP_ACC: begin
				mul_a = delta_q;
				mul_b = in_q.time_step;
			end
			OP_PROP: begin
				mul_a = delta_q;
				mul_b = regs.gain_p;
			end
			OP_PI: begin
				mul_a = acc_q;
				mul_b = regs.gain_i;
			end
			OP_FF: begin
				mul_a = ms_q;
				mul_b = regs.back_emf_gain;
			end
			OP_CMD: begin
				mul_a = ua_q;
				mul_b = regs.output_scale;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Sums after the products that need one, each saturated to 32 bits before any clamp.
	assign ilim    = $signed({2'b00, regs.current_limit_voltage});
	assign vlim    = $signed({2'b00, regs.voltage_limit});
	assign delta_n = sat32({mul_res[31], mul_res} - {ms_q[31], ms_q});
	assign acc_n   = sat32({mul_res[31], mul_res} + {integ_rd[31], integ_rd});
	assign pi_raw  = sat32({p_q[31], p_q} + {mul_res[31], mul_res});
	assign ua_raw  = sat32({pi_q[31], pi_q} + {mul_res[31], mul_res});

	always_comb begin
		if ($signed({pi_raw[31], pi_raw}) > ilim) begin
			pi_n = ilim[31:0];
			cs_n = 1'b1;
		end else if ($signed({pi_raw[31], pi_raw}) < -ilim) begin
			pi_n = 32'(-ilim);
			cs_n = 1'b1;
		end else begin
			pi_n = pi_raw;
			cs_n = 1'b0;
		end
	end

	always_comb begin
		if ($signed({ua_raw[31], ua_raw}) > vlim) begin
			ua_n = vlim[31:0];
			vs_n = 1'b1;
		end else if ($signed({ua_raw[31], ua_raw}) < -vlim) begin
			ua_n = 32'(-vlim);
			vs_n = 1'b1;
		end else begin
			ua_n = ua_raw;
			vs_n = 1'b0;
		end
	end

	// Command limit first to the percent range, then to the 24-bit field.
	always_comb begin
		if (mul_res > CMD_LIM) begin
			cmd_lim = CMD_LIM;
		end else if (mul_res < -CMD_LIM) begin
			cmd_lim = -CMD_LIM;
		end else begin
			cmd_lim = mul_res;
		end
		if (cmd_lim > CMD_MAX) begin
			cmd_clip = CMD_MAX;
		end else if (cmd_lim < CMD_MIN) begin
			cmd_clip = CMD_MIN;
		end else begin
			cmd_clip = cmd_lim;
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_MS;
			lane_q      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MOTOR_COUNT; i++) begin
				integ_q[i] <= '0;
			end
		end else begin
			// In the output state a drained result is replaced at once below.
			if (out_valid_q && !out_stall && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_START;
						op_q    <= OP_MS;
						lane_q  <= 1'b0;
					end
				end
				ST_START: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (mul_done) begin
						state_q <= ST_START;
						op_q    <= op_q + 1'b1;
						if (op_q == OP_FF && !cs_q && !vs_n) begin
							integ_q[entry] <= acc_q;
						end
						if (op_q == OP_CMD) begin
							op_q <= OP_MS;
							if (lane_q) begin
								state_q <= ST_OUT;
							end else begin
								lane_q <= 1'b1;
							end
						end
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: no reset needed.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			in_q <= in_data;
		end
		if (state_q == ST_OUT && out_free) begin
			out_q <= res_q;
		end
		if (state_q == ST_WAIT && mul_done) begin
			unique case (op_q)
				OP_MS:    ms_q    <= mul_res;
				OP_DELTA: delta_q <= delta_n;
				OP_ACC:   acc_q   <= acc_n;
				OP_PROP:  p_q     <= mul_res;
				OP_PI: begin
					pi_q <= pi_n;
					cs_q <= cs_n;
				end
				OP_FF: begin
					ua_q <= ua_n;
					vs_q <= vs_n;
				end
				OP_CMD: begin
					if (lane_q) begin
						res_q.right_command         <= cmd_clip[23:0];
						res_q.right_current_limited <= cs_q;
						res_q.right_voltage_limited <= vs_q;
					end else begin
						res_q.left_command          <= cmd_clip[23:0];
						res_q.left_current_limited  <= cs_q;
						res_q.left_voltage_limited  <= vs_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[hw/rtl/dmpsc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Configuration register bank
// Eight 31-bit controller settings written through a valid/ready channel.
// Writes to indexes beyond the bank are dropped.
// ----------------------------------------------------------------------------
module dmpsc_cfg_regs
	import dmpsc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output cfg_regs_t            regs
);

	cfg_regs_t regs_q;

	assign cfg_ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.gain_p                <= RST_GAIN_P;
			regs_q.gain_i                <= RST_GAIN_I;
			regs_q.gear_ratio            <= RST_GEAR_RATIO;
			regs_q.speed_scale           <= RST_SPEED_SCALE;
			regs_q.back_emf_gain         <= RST_BACK_EMF_GAIN;
			regs_q.current_limit_voltage <= RST_CUR_LIMIT_V;
			regs_q.voltage_limit         <= RST_VOLTAGE_LIMIT;
			regs_q.output_scale          <= RST_OUTPUT_SCALE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_GAIN_P:        regs_q.gain_p                <= cfg_data;
				REG_GAIN_I:        regs_q.gain_i                <= cfg_data;
				REG_GEAR_RATIO:    regs_q.gear_ratio            <= cfg_data;
				REG_SPEED_SCALE:   regs_q.speed_scale           <= cfg_data;
				REG_BACK_EMF_GAIN: regs_q.back_emf_gain         <= cfg_data;
				REG_CUR_LIMIT_V:   regs_q.current_limit_voltage <= cfg_data;
				REG_VOLTAGE_LIMIT: regs_q.voltage_limit         <= cfg_data;
				REG_OUTPUT_SCALE:  regs_q.output_scale          <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule

[hw/rtl/dmpsc_serial_mul.sv]
// ----------------------------------------------------------------------------
// Digit-serial fixed-point multiplier
// Signed 32-bit by unsigned 31-bit product, two multiplier bits per cycle,
// floored by the fraction width and saturated to the signed 32-bit range.
// ----------------------------------------------------------------------------
module dmpsc_serial_mul
	import dmpsc_pkg::*;
#(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] a,
	input  logic [30:0]        b,
	output logic               done,
	output logic signed [31:0] result
);

	localparam int DIGITS = 16;
	localparam int CNT_W  = $clog2(DIGITS);

	logic               busy_q;
	logic               fin_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic signed [33:0] a1_q;
	logic signed [33:0] a3_q;
	logic [31:0]        b_q;
	logic signed [35:0] hi_q;
	logic [31:0]        lo_q;
	logic signed [31:0] result_q;

	logic signed [33:0] a1_in;
	logic signed [33:0] a3_in;
	logic signed [33:0] pp;
	logic signed [35:0] sum;
	logic signed [67:0] prod;
	logic signed [67:0] shifted;
	logic signed [31:0] sat_res;

	assign a1_in = {{2{a[31]}}, a};
	assign a3_in = a1_in + (a1_in <<< 1);

	always_comb begin
		unique case (b_q[1:0])
			2'd0: pp = '0;
			2'd1: pp = a1_q;
			2'd2: pp = a1_q <<< 1;
			2'd3: pp = a3_q;
			default: pp = '0;
		endcase
	end

	assign sum     = hi_q + {{2{pp[33]}}, pp};
	assign prod    = $signed({hi_q, lo_q});
	assign shifted = prod >>> FRACTION_BITS;

	always_comb begin
		if (shifted > 68'sd2147483647) begin
			sat_res = 32'sh7FFF_FFFF;
		end else if (shifted < -68'sd2147483648) begin
			sat_res = 32'sh8000_0000;
		end else begin
			sat_res = $signed(shifted[31:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIGITS - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a1_q <= a1_in;
			a3_q <= a3_in;
			b_q  <= {1'b0, b};
			hi_q <= '0;
			lo_q <= '0;
		end else if (busy_q) begin
			hi_q <= sum >>> 2;
			lo_q <= {sum[1:0], lo_q[31:2]};
			b_q  <= b_q >> 2;
		end
		if (fin_q) begin
			result_q <= sat_res;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

[test/pi_speed_checker.sv]
// ----------------------------------------------------------------------------
// Dual motor PI speed control checker
// Follows the input, output and settings channels, models both speed loops
// with their integrators, and compares every command transaction returned by
// the controller with the modelled one, field by field.
// ----------------------------------------------------------------------------
module pi_speed_checker
	import dmpsc_pkg::*;
#(
	parameter int MOTOR_COUNT   = MOTOR_COUNT_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  in_item_t             in_data,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  out_item_t            out_data,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   mismatches,
	output int                   outstanding
);

	localparam longint S32_MAX   = (longint'(1) << 31) - 1;
	localparam longint S32_MIN   = -(longint'(1) << 31);
	localparam longint CMD_LIMIT = longint'(100) << FRACTION_BITS;
	localparam longint CMD_MAX24 = (longint'(1) << 23) - 1;
	localparam longint CMD_MIN24 = -(longint'(1) << 23);

	logic [CFG_W-1:0] settings [REG_COUNT];
	longint           integrator [MOTOR_COUNT];
	out_item_t        expected_commands [$];
	out_item_t        want;
	int               errors;

	function automatic longint clip32(input longint v);
		if (v > S32_MAX) return S32_MAX;
		if (v < S32_MIN) return S32_MIN;
		return v;
	endfunction

	// Operands stay within 32 bits, so the 64-bit product cannot overflow and
	// the arithmetic shift rounds towards minus infinity.
	function automatic longint fixed_mul(input longint a, input longint b);
		return clip32((a * b) >>> FRACTION_BITS);
	endfunction

	function automatic logic signed [23:0] lane_command(input int lane_no,
			input longint speed_ref, input longint meas_speed, input longint dt_q,
			output logic cur_clamp, output logic volt_clamp);
		int     k;
		longint motor_spd, err, acc, pi, ua, cmd, ilim, vlim, oscale;
		k         = (lane_no < MOTOR_COUNT) ? lane_no : MOTOR_COUNT - 1;
		ilim      = settings[REG_CUR_LIMIT_V];
		vlim      = settings[REG_VOLTAGE_LIMIT];
		oscale    = settings[REG_OUTPUT_SCALE];
		motor_spd = fixed_mul(meas_speed, settings[REG_SPEED_SCALE]);
		err       = clip32(fixed_mul(speed_ref, settings[REG_GEAR_RATIO]) - motor_spd);
		acc       = clip32(fixed_mul(dt_q, err) + integrator[k]);
		pi        = clip32(fixed_mul(err, settings[REG_GAIN_P])
				+ fixed_mul(settings[REG_GAIN_I], acc));
		cur_clamp  = 1'b0;
		volt_clamp = 1'b0;
		if (pi > ilim) begin
			pi = ilim;
			cur_clamp = 1'b1;
		end else if (pi < -ilim) begin
			pi = -ilim;
			cur_clamp = 1'b1;
		end
		ua = clip32(pi + fixed_mul(settings[REG_BACK_EMF_GAIN], motor_spd));
		if (ua > vlim) begin
			ua = vlim;
			volt_clamp = 1'b1;
		end else if (ua < -vlim) begin
			ua = -vlim;
			volt_clamp = 1'b1;
		end
		// Anti-windup: the integrator only moves while neither clamp acts.
		if (!cur_clamp && !volt_clamp) begin
			integrator[k] = acc;
		end
		cmd = (ua * oscale) >>> FRACTION_BITS;
		if (cmd > CMD_LIMIT) cmd = CMD_LIMIT;
		if (cmd < -CMD_LIMIT) cmd = -CMD_LIMIT;
		if (cmd > CMD_MAX24) cmd = CMD_MAX24;
		if (cmd < CMD_MIN24) cmd = CMD_MIN24;
		return cmd[23:0];
	endfunction

	function automatic out_item_t predict_commands(input in_item_t item);
		out_item_t res;
		logic      lc, lv, rc, rv;
		res.left_command  = lane_command(0, item.left_speed_ref, item.left_wheel_speed,
				item.time_step, lc, lv);
		res.right_command = lane_command(1, item.right_speed_ref, item.right_wheel_speed,
				item.time_step, rc, rv);
		res.left_current_limited  = lc;
		res.left_voltage_limited  = lv;
		res.right_current_limited = rc;
		res.right_voltage_limited = rv;
		return res;
	endfunction

	task automatic compare_field(input string field, input logic signed [31:0] want_v,
			input logic signed [31:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settings[REG_GAIN_P]        = RST_GAIN_P;
			settings[REG_GAIN_I]        = RST_GAIN_I;
			settings[REG_GEAR_RATIO]    = RST_GEAR_RATIO;
			settings[REG_SPEED_SCALE]   = RST_SPEED_SCALE;
			settings[REG_BACK_EMF_GAIN] = RST_BACK_EMF_GAIN;
			settings[REG_CUR_LIMIT_V]   = RST_CUR_LIMIT_V;
			settings[REG_VOLTAGE_LIMIT] = RST_VOLTAGE_LIMIT;
			settings[REG_OUTPUT_SCALE]  = RST_OUTPUT_SCALE;
			foreach (integrator[i]) integrator[i] = 0;
			expected_commands.delete();
			errors = 0;
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			// Writes beyond the last register are dropped by the controller.
			if (cfg_valid && cfg_ready && cfg_index < REG_COUNT) begin
				settings[cfg_index] = cfg_data;
			end
			if (out_valid && !out_stall) begin
				if (expected_commands.size() == 0) begin
					$display("%0t: command transaction with none outstanding, expected none, got %h",
							$time, out_data);
					errors++;
				end else begin
					want = expected_commands.pop_front();
					compare_field("left_command", want.left_command, out_data.left_command);
					compare_field("right_command", want.right_command, out_data.right_command);
					compare_field("left_current_limited", want.left_current_limited,
							out_data.left_current_limited);
					compare_field("left_voltage_limited", want.left_voltage_limited,
							out_data.left_voltage_limited);
					compare_field("right_current_limited", want.right_current_limited,
							out_data.right_current_limited);
					compare_field("right_voltage_limited", want.right_voltage_limited,
							out_data.right_voltage_limited);
				end
			end
			if (in_valid && !in_stall) begin
				expected_commands.push_back(predict_commands(in_data));
			end
			mismatches  <= errors;
			outstanding <= expected_commands.size();
		end
	end

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// Dual motor PI speed control testbench
// Drives speed ticks and settings into the controller under random idling on
// both channels, across several register settings including the extremes.
// A checker beside the controller predicts each command transaction and
// counts mismatches; this module builds the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
	import dmpsc_pkg::*;

	// The 1500-odd ticks, with idling on both sides, take well under this
	// limit, so it leaves ample room.
	localparam int CYCLE_LIMIT = 2_000_000;
	// Further cycles allowed after the last command, a little over one tick.
	localparam int TAIL_CYCLES = 300;

	localparam int                Q_ONE   = 1 << FRACTION_BITS_DEF;
	localparam logic signed [31:0] S_MAX   = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S_MIN   = 32'sh8000_0000;
	localparam logic [30:0]        DT_MAX  = 31'h7FFF_FFFF;
	localparam logic [CFG_W-1:0]   SET_MAX = {CFG_W{1'b1}};

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	in_item_t             in_data   = '0;
	logic                 out_stall = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;
	logic                 in_stall;
	logic                 out_valid;
	logic                 cfg_ready;
	out_item_t            out_data;

	int mismatches;
	int outstanding;
	int cycles = 0;

	// When set, neither side idles, so ticks and commands run back to back.
	bit steady = 1'b0;

	// Operating points that the well-formed ticks hover around, per lane.
	int base_left  = 0;
	int base_right = 0;

	dual_motor_pi_speed_control u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pi_speed_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog: a hang anywhere ends the run as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Command sink. For every command it draws a random hold, which may be
	// zero. The stall goes up straight after the previous transaction, so it
	// also covers the stretch while the controller is still working, and it
	// is kept for the drawn hold once the command is presented.
	initial begin : command_sink
		int hold;
		forever begin
			hold = steady ? 0 : $urandom_range(0, 4);
			out_stall <= (hold > 0);
			do @(posedge clk); while (!out_valid);
			if (hold > 0) begin
				repeat (hold - 1) @(posedge clk);
				out_stall <= 1'b0;
				do @(posedge clk); while (!out_valid);
			end
		end
	end

	// Offers one tick after a random gap and holds it until it is taken.
	// It returns straight after the accepting edge, with valid still high,
	// so the next call can keep valid up without lowering it in between.
	task automatic send_tick(input in_item_t item);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic tick(input logic signed [31:0] lref, input logic signed [31:0] rref,
			input logic signed [31:0] lws, input logic signed [31:0] rws,
			input logic [30:0] dt);
		in_item_t item;
		item.left_speed_ref    = lref;
		item.right_speed_ref   = rref;
		item.left_wheel_speed  = lws;
		item.right_wheel_speed = rws;
		item.time_step         = dt;
		send_tick(item);
	endtask

	// Holds the sender back until every outstanding command has come back.
	// The first edge is always waited so that the checker has counted the
	// tick that was accepted just before.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Leaves valid high on return; the caller drops it after the last write.
	task automatic load_setting(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	function automatic logic [CFG_W-1:0] default_setting(input logic [CFG_IDX_W-1:0] idx);
		case (idx)
			REG_GAIN_P:        return RST_GAIN_P;
			REG_GAIN_I:        return RST_GAIN_I;
			REG_GEAR_RATIO:    return RST_GEAR_RATIO;
			REG_SPEED_SCALE:   return RST_SPEED_SCALE;
			REG_BACK_EMF_GAIN: return RST_BACK_EMF_GAIN;
			REG_CUR_LIMIT_V:   return RST_CUR_LIMIT_V;
			REG_VOLTAGE_LIMIT: return RST_VOLTAGE_LIMIT;
			REG_OUTPUT_SCALE:  return RST_OUTPUT_SCALE;
			default:           return '0;
		endcase
	endfunction

	// Mostly a multiple of the reset value between an eighth and three
	// times, so the loop stays in a useful region, with the odd extreme.
	function automatic logic [CFG_W-1:0] random_setting(input logic [CFG_IDX_W-1:0] idx);
		longint scaled;
		case ($urandom_range(0, 9))
			0: return '0;
			1: return SET_MAX;
			2: return CFG_W'($urandom);
			default: begin
				scaled = (longint'(default_setting(idx)) * $urandom_range(1, 24)) / 8;
				if (scaled > longint'(SET_MAX)) scaled = SET_MAX;
				return scaled[CFG_W-1:0];
			end
		endcase
	endfunction

	// Writes every register, either to its reset value or to one value, and
	// then one write to an index past the last register, which must be lost.
	task automatic program_all(input bit restore, input logic [CFG_W-1:0] value);
		logic [CFG_IDX_W-1:0] stray;
		for (int i = 0; i < REG_COUNT; i++) begin
			load_setting(CFG_IDX_W'(i), restore ? default_setting(CFG_IDX_W'(i)) : value);
		end
		stray = CFG_IDX_W'(REG_COUNT + $urandom_range(0, 7));
		load_setting(stray, SET_MAX);
		cfg_valid <= 1'b0;
	endtask

	task automatic program_random();
		logic [CFG_IDX_W-1:0] stray;
		for (int i = 0; i < REG_COUNT; i++) begin
			load_setting(CFG_IDX_W'(i), random_setting(CFG_IDX_W'(i)));
		end
		if ($urandom_range(0, 1) == 1) begin
			stray = CFG_IDX_W'(REG_COUNT + $urandom_range(0, 7));
			load_setting(stray, CFG_W'($urandom));
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic int spread(input int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic logic signed [31:0] wild_speed();
		case ($urandom_range(0, 5))
			0:       return S_MAX;
			1:       return S_MIN;
			2:       return 0;
			3:       return -1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [30:0] wild_step();
		case ($urandom_range(0, 3))
			0:       return DT_MAX;
			1:       return '0;
			default: return 31'($urandom);
		endcase
	endfunction

	// Most ticks look like a running drive: references near a slowly moving
	// operating point, wheel speeds close to them and a short time step, so
	// the integrators really build up. The rest are wide and wild values.
	function automatic in_item_t random_tick();
		in_item_t item;
		int       roll;
		roll = $urandom_range(0, 99);
		if (roll < 65) begin
			if ($urandom_range(0, 19) == 0) begin
				base_left  = spread(20 * Q_ONE);
				base_right = spread(20 * Q_ONE);
			end
			item.left_speed_ref    = base_left + spread(Q_ONE / 4);
			item.right_speed_ref   = base_right + spread(Q_ONE / 4);
			item.left_wheel_speed  = item.left_speed_ref + spread(2 * Q_ONE);
			item.right_wheel_speed = item.right_speed_ref + spread(2 * Q_ONE);
			item.time_step         = 31'($urandom_range(16, 1000));
		end else if (roll < 85) begin
			item.left_speed_ref    = spread(1 << 24);
			item.right_speed_ref   = spread(1 << 24);
			item.left_wheel_speed  = spread(1 << 24);
			item.right_wheel_speed = spread(1 << 24);
			item.time_step         = 31'($urandom_range(0, 1 << 20));
		end else begin
			item.left_speed_ref    = wild_speed();
			item.right_speed_ref   = wild_speed();
			item.left_wheel_speed  = wild_speed();
			item.right_wheel_speed = wild_speed();
			item.time_step         = wild_step();
		end
		return item;
	endfunction

	task automatic run_random(input int count);
		repeat (count) send_tick(random_tick());
		wait_for_results();
	endtask

	initial begin : stimulus
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings. Zero input, a settled drive, then a small steady
		// error so that the integrators climb, then the extremes of every
		// field, which saturate the products and sums and trip both clamps.
		tick(0, 0, 0, 0, 0);
		tick(10 * Q_ONE, -10 * Q_ONE, 10 * Q_ONE, -10 * Q_ONE, 66);
		repeat (3) tick(10 * Q_ONE, -10 * Q_ONE, 9 * Q_ONE, -9 * Q_ONE, 655);
		tick(S_MAX, S_MIN, 0, 0, DT_MAX);
		tick(0, 0, S_MAX, S_MIN, 655);
		tick(S_MAX, S_MIN, S_MAX, S_MIN, 1);
		tick(S_MAX, S_MIN, S_MIN, S_MAX, DT_MAX);
		tick(-1, 1, 1, -1, 1);
		run_random(250);

		// Every register at its maximum: the limits cannot be reached from
		// above, and large voltages drive the command to its percent bound.
		program_all(1'b0, SET_MAX);
		tick(S_MAX, S_MIN, 0, 0, DT_MAX);
		tick(S_MIN, S_MAX, S_MAX, S_MIN, DT_MAX);
		run_random(80);

		// Every register at zero: every product is zero, so neither clamp acts.
		steady = 1'b1;
		program_all(1'b0, '0);
		run_random(80);

		// With no gains and open limits the clamps never act, so a huge
		// error times a huge step drives the left integrator into its upper bound
		// and the right into its lower one, and then each into the opposite one.
		steady = 1'b0;
		program_all(1'b1, '0);
		load_setting(REG_GAIN_P, '0);
		load_setting(REG_GAIN_I, '0);
		load_setting(REG_BACK_EMF_GAIN, '0);
		load_setting(REG_CUR_LIMIT_V, SET_MAX);
		load_setting(REG_VOLTAGE_LIMIT, SET_MAX);
		cfg_valid <= 1'b0;
		repeat (2) tick(S_MAX, S_MIN, 0, 0, DT_MAX);
		repeat (2) tick(S_MIN, S_MAX, 0, 0, DT_MAX);
		wait_for_results();

		// Random settings, each phase starting from the saturated or wound
		// up integrators left by the one before.
		repeat (10) begin
			steady = ($urandom_range(0, 2) == 0);
			program_random();
			run_random(90);
		end

		steady = 1'b0;
		program_all(1'b1, '0);
		run_random(200);

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
